[sv/nnir_pkg.sv]
// Shared types and constants of the nearest-neighbor image rotator.
// No dependencies; imported by the interfaces and the rotator top level.
package nnir_pkg;

  localparam int OP_W    = 1;
  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;
  localparam int SRCW_W  = 10;
  localparam int OUTW_W  = 11;
  localparam int TRIG_W  = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_OUT_WIDTH  = 3'd2,
    CFG_OUT_HEIGHT = 3'd3,
    CFG_ROT_COS    = 3'd4,
    CFG_ROT_SIN    = 3'd5
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  localparam logic [SRCW_W-1:0] SRC_WIDTH_RST  = 10'd512;
  localparam logic [SRCW_W-1:0] SRC_HEIGHT_RST = 10'd512;
  localparam logic [OUTW_W-1:0] OUT_WIDTH_RST  = 11'd512;
  localparam logic [OUTW_W-1:0] OUT_HEIGHT_RST = 11'd512;
  localparam logic [TRIG_W-1:0] ROT_COS_RST    = 16'd16384;
  localparam logic [TRIG_W-1:0] ROT_SIN_RST    = 16'd0;

  // result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int OQ_CW    = 4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             in_src;
  } result_t;

endpackage

[sv/nnir_if.sv]
// Valid/ready channel interfaces for the rotator's input and result beats.
// Depends on nnir_pkg.
interface nnir_in_if;
  import nnir_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [PIX_W-1:0]   pixel_value;

  modport source (output valid, output operation, output x_coord, output y_coord,
                  output pixel_value, input ready);
  modport sink   (input valid, input operation, input x_coord, input y_coord,
                  input pixel_value, output ready);
endinterface

interface nnir_out_if;
  import nnir_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] rotated_pixel;
  logic             inside_source;

  modport source (output valid, output rotated_pixel, output inside_source, input ready);
  modport sink   (input valid, input rotated_pixel, input inside_source, output ready);
endinterface

[sv/nnir_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module nnir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

[sv/nearest_neighbor_image_rotator_unit.sv]
// Nearest-neighbor image rotator, top level.
// Depends on nnir_pkg, nnir_if (nnir_in_if, nnir_out_if) and nnir_ram.
//
// Usage: in_ch carries load and query beats. A load (operation 0) writes
// pixel_value into the frame store at (x_coord, y_coord) and returns no beat.
// A query (operation 1) maps an output coordinate back into the source image
// and returns one beat on out_ch: the source pixel and inside_source = 1, or
// 0 and inside_source = 0 when the point is off the output or maps outside.
// cfg_* writes the size and Q1.F cosine/sine registers; write only while idle.
// Throughput: one beat per cycle while in_ch.ready is high, loads and queries mixed freely.
// Path: a query passes the input register, the product stage with four
// multiplies in parallel, the sum stage, the truncation/bounds stage, the
// frame store read and the result queue write before out_ch.valid rises;
// a ready receiver then takes the result beat.
// Every beat makes at most one frame store access, in order, so a load is
// always seen by every later query.
// When out_ch stalls, results collect in an 8-entry queue; in_ch.ready drops
// once queued plus in-flight queries reach 8, so no result is lost.
// Reset (synchronous, rst_n low) empties the pipeline and queue and restores
// the register defaults; frame store contents are undefined until loaded.
module nearest_neighbor_image_rotator_unit #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nnir_in_if.sink                     in_ch,
  nnir_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [nnir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnir_pkg::CFG_DW-1:0] cfg_wdata
);

  import nnir_pkg::*;

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = 11;
  localparam int PW    = 27;
  localparam int NW    = ((TRIG_FRAC_BITS + 10 > PW) ? TRIG_FRAC_BITS + 10 : PW) + 2;
  localparam int XW    = NW - TRIG_FRAC_BITS;
  localparam int TB    = (1 << TRIG_FRAC_BITS) - 1;

  // configuration registers
  logic        [SRCW_W-1:0] src_width_r, src_height_r;
  logic        [OUTW_W-1:0] out_width_r, out_height_r;
  logic signed [TRIG_W-1:0] rot_cos_r, rot_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      out_width_r  <= OUT_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
      rot_cos_r    <= ROT_COS_RST;
      rot_sin_r    <= ROT_SIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SRCW_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SRCW_W-1:0];
        CFG_OUT_WIDTH:  out_width_r  <= cfg_wdata[OUTW_W-1:0];
        CFG_OUT_HEIGHT: out_height_r <= cfg_wdata[OUTW_W-1:0];
        CFG_ROT_COS:    rot_cos_r    <= cfg_wdata[TRIG_W-1:0];
        CFG_ROT_SIN:    rot_sin_r    <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective source size, clamped to the store
  logic [SRCW_W-1:0] sw, sh;
  logic signed [NW-1:0] ocx_f, ocy_f;

  assign sw = (32'(src_width_r) > MAX_SRC_WIDTH) ? SRCW_W'(MAX_SRC_WIDTH) : src_width_r;
  assign sh = (32'(src_height_r) > MAX_SRC_HEIGHT) ? SRCW_W'(MAX_SRC_HEIGHT) : src_height_r;
  assign ocx_f = NW'({1'b0, sw[SRCW_W-1:1]}) <<< TRIG_FRAC_BITS;
  assign ocy_f = NW'({1'b0, sh[SRCW_W-1:1]}) <<< TRIG_FRAC_BITS;

  // pipeline registers
  logic                 v1_r, q1_r, ok1_r;
  logic [COORD_W-1:0]   x1_r, y1_r;
  logic [PIX_W-1:0]     pix1_r;
  logic signed [DW-1:0] dx1_r, dy1_r;

  logic                 v2_r, q2_r, ok2_r;
  logic [COORD_W-1:0]   x2_r, y2_r;
  logic [PIX_W-1:0]     pix2_r;
  logic signed [PW-1:0] cdx2_r, sdy2_r, cdy2_r, sdx2_r;

  logic                 v3_r, q3_r, ok3_r;
  logic [COORD_W-1:0]   x3_r, y3_r;
  logic [PIX_W-1:0]     pix3_r;
  logic signed [NW-1:0] numx3_r, numy3_r;

  logic                 v4_r, q4_r, acc4_r, we4_r;
  logic [COORD_W-1:0]   ax4_r, ay4_r;
  logic [PIX_W-1:0]     pix4_r;

  logic                 v5_r, hit5_r;

  logic in_acc;
  logic ok1_nxt;
  logic signed [DW-1:0] dx1_nxt, dy1_nxt;
  logic signed [NW-1:0] numx3_nxt, numy3_nxt;
  logic signed [NW-1:0] sumx, sumy;
  logic signed [XW-1:0] xo, yo;
  logic                 in_src;
  logic                 acc4_nxt, we4_nxt;
  logic [COORD_W-1:0]   ax4_nxt, ay4_nxt;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    dx1_nxt = DW'(in_ch.x_coord) - DW'(out_width_r[OUTW_W-1:1]);
    dy1_nxt = DW'(in_ch.y_coord) - DW'(out_height_r[OUTW_W-1:1]);
    if (in_ch.operation == OP_QUERY) begin
      ok1_nxt = (OUTW_W'(in_ch.x_coord) < out_width_r) &&
                (OUTW_W'(in_ch.y_coord) < out_height_r);
    end else begin
      ok1_nxt = (32'(in_ch.x_coord) < MAX_SRC_WIDTH) &&
                (32'(in_ch.y_coord) < MAX_SRC_HEIGHT);
    end
  end

  always_comb begin
    numx3_nxt = ocx_f + NW'(cdx2_r) + NW'(sdy2_r);
    numy3_nxt = ocy_f + NW'(cdy2_r) - NW'(sdx2_r);
  end

  // truncation toward zero, bounds test, access select
  always_comb begin
    sumx   = numx3_r + (numx3_r[NW-1] ? NW'(TB) : '0);
    sumy   = numy3_r + (numy3_r[NW-1] ? NW'(TB) : '0);
    xo     = sumx[NW-1:TRIG_FRAC_BITS];
    yo     = sumy[NW-1:TRIG_FRAC_BITS];
    in_src = !xo[XW-1] && !yo[XW-1] &&
             (xo < XW'(sw)) && (yo < XW'(sh));
    if (q3_r) begin
      acc4_nxt = ok3_r && in_src;
      we4_nxt  = 1'b0;
      ax4_nxt  = xo[COORD_W-1:0];
      ay4_nxt  = yo[COORD_W-1:0];
    end else begin
      acc4_nxt = ok3_r;
      we4_nxt  = ok3_r;
      ax4_nxt  = x3_r;
      ay4_nxt  = y3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r && q4_r;
    end
    q1_r   <= (in_ch.operation == OP_QUERY);
    ok1_r  <= ok1_nxt;
    x1_r   <= in_ch.x_coord;
    y1_r   <= in_ch.y_coord;
    pix1_r <= in_ch.pixel_value;
    dx1_r  <= dx1_nxt;
    dy1_r  <= dy1_nxt;

    q2_r   <= q1_r;
    ok2_r  <= ok1_r;
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    pix2_r <= pix1_r;
    cdx2_r <= PW'(rot_cos_r) * PW'(dx1_r);
    sdy2_r <= PW'(rot_sin_r) * PW'(dy1_r);
    cdy2_r <= PW'(rot_cos_r) * PW'(dy1_r);
    sdx2_r <= PW'(rot_sin_r) * PW'(dx1_r);

    q3_r    <= q2_r;
    ok3_r   <= ok2_r;
    x3_r    <= x2_r;
    y3_r    <= y2_r;
    pix3_r  <= pix2_r;
    numx3_r <= numx3_nxt;
    numy3_r <= numy3_nxt;

    q4_r   <= q3_r;
    acc4_r <= acc4_nxt;
    we4_r  <= we4_nxt;
    ax4_r  <= ax4_nxt;
    ay4_r  <= ay4_nxt;
    pix4_r <= pix3_r;

    hit5_r <= q4_r && acc4_r;
  end

  // frame store: at most one access per beat, in order
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [PIX_W-1:0] mem_rdata;

  assign mem_addr = AW'(32'(ay4_r) * 32'(MAX_SRC_WIDTH) + 32'(ax4_r));
  assign mem_we   = v4_r && we4_r;

  nnir_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (pix4_r),
    .rdata (mem_rdata)
  );

  // result queue with credit count over in-flight queries
  result_t          oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_CW-1:0] inflight;
  logic             push, pop;
  result_t          push_data;

  assign inflight = OQ_CW'(v1_r && q1_r) + OQ_CW'(v2_r && q2_r) +
                    OQ_CW'(v3_r && q3_r) + OQ_CW'(v4_r && q4_r) + OQ_CW'(v5_r);
  assign in_ch.ready = (cnt_r + inflight) < OQ_CW'(OQ_DEPTH);

  assign push = v5_r;
  assign pop  = out_ch.valid && out_ch.ready;
  assign push_data.pixel  = hit5_r ? mem_rdata : '0;
  assign push_data.in_src = hit5_r;
  assign cnt_nxt = cnt_r + OQ_CW'(push) - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      oq_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.rotated_pixel = oq_r[rd_ptr_r].pixel;
  assign out_ch.inside_source = oq_r[rd_ptr_r].in_src;

endmodule
